// ===== rtl/core/keyed_counting_slot_table_macros.svh =====
// assertion macros used by the checker file of the slot table
// no dependencies
`ifndef KEYED_COUNTING_SLOT_TABLE_MACROS_SVH
`define KEYED_COUNTING_SLOT_TABLE_MACROS_SVH

// same-cycle implication, off during reset
`define KCST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kcst check failed");

// next-cycle implication, off during reset
`define KCST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kcst check failed");

// next-cycle implication, also active during reset
`define KCST_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("kcst check failed");

`endif

// ===== rtl/core/kcst_pkg.sv =====
// types and codes of the keyed counting slot table
// no dependencies
`default_nettype none

package kcst_pkg;

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic       func;
      logic [7:0] item_key;
      logic [3:0] slot_index;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot_used;
      logic [15:0] new_count;
      logic [4:0]  free_slots;
   } rsp_payload_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic set_vld;
      logic clr_vld;
   } tbl_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/kcst_req_if.sv =====
// request channel: valid, ready and request payload
// depends on kcst_pkg
`default_nettype none

interface kcst_req_if;
   logic                     valid;
   logic                     ready;
   kcst_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kcst_rsp_if.sv =====
// response channel: valid, ready and result payload
// depends on kcst_pkg
`default_nettype none

interface kcst_rsp_if;
   logic                     valid;
   logic                     ready;
   kcst_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kcst_table.sv =====
// slot storage: key/count memory, valid bits and free-slot counter
// depends on kcst_pkg
`default_nettype none

module kcst_table #(
   parameter int SLOTS      = 16,
   parameter int COUNT_BITS = 16,
   localparam int SLOT_W    = $clog2(SLOTS),
   localparam int FREE_W    = $clog2(SLOTS + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire kcst_pkg::tbl_cmd_type   cmd,
   input  wire logic [SLOT_W-1:0]       rd_addr,
   input  wire logic [SLOT_W-1:0]       wr_addr,
   input  wire logic [7:0]              wr_key,
   input  wire logic [COUNT_BITS-1:0]   wr_count,
   output logic [7:0]                   rd_key,
   output logic [COUNT_BITS-1:0]        rd_count,
   output logic                         rd_valid,
   output logic [FREE_W-1:0]            free_next
);

   logic [8+COUNT_BITS-1:0] mem [SLOTS];
   logic [8+COUNT_BITS-1:0] rd_data_ff;
   logic [SLOT_W-1:0]       rd_addr_ff;
   logic [SLOTS-1:0]        valid_ff;
   logic [SLOTS-1:0]        valid_in;
   logic [FREE_W-1:0]       free_ff;
   logic [FREE_W-1:0]       free_in;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= {wr_key, wr_count};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      free_in  = free_ff;
      if (cmd.set_vld) begin
         valid_in[wr_addr] = 1'b1;
         if (!valid_ff[wr_addr]) begin
            free_in = free_ff - FREE_W'(1);
         end
      end else if (cmd.clr_vld) begin
         valid_in[wr_addr] = 1'b0;
         if (valid_ff[wr_addr]) begin
            free_in = free_ff + FREE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         free_ff  <= FREE_W'(SLOTS);
      end else begin
         valid_ff <= valid_in;
         free_ff  <= free_in;
      end
   end

   assign rd_key    = rd_data_ff[8+COUNT_BITS-1:COUNT_BITS];
   assign rd_count  = rd_data_ff[COUNT_BITS-1:0];
   assign rd_valid  = valid_ff[rd_addr_ff];
   assign free_next = free_in;

endmodule

`default_nettype wire

// ===== rtl/core/kcst_ctrl.sv =====
// request sequencer: slot scan, update decision and response register
// depends on kcst_pkg; drives kcst_table
`default_nettype none

module kcst_ctrl #(
   parameter int SLOTS         = 16,
   parameter int ITEM_ID_LIMIT = 16,
   parameter int COUNT_BITS    = 16,
   localparam int SLOT_W       = $clog2(SLOTS),
   localparam int FREE_W       = $clog2(SLOTS + 1)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire kcst_pkg::req_payload_type req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output kcst_pkg::rsp_payload_type      rsp_data,
   output kcst_pkg::tbl_cmd_type          tbl_cmd,
   output logic [SLOT_W-1:0]              tbl_rd_addr,
   output logic [SLOT_W-1:0]              tbl_wr_addr,
   output logic [7:0]                     tbl_wr_key,
   output logic [COUNT_BITS-1:0]          tbl_wr_count,
   input  wire logic [7:0]                tbl_rd_key,
   input  wire logic [COUNT_BITS-1:0]     tbl_rd_count,
   input  wire logic                      tbl_rd_valid,
   input  wire logic [FREE_W-1:0]         tbl_free_next
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;
   localparam logic [1:0] ST_CLR  = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [7:0]                key_ff, key_in;
   logic [3:0]                idx_ff, idx_in;
   logic [SLOT_W:0]           issue_ff, issue_in;
   logic                      cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0]         cmp_addr_ff, cmp_addr_in;
   logic                      match_ff, match_in;
   logic [SLOT_W-1:0]         match_slot_ff, match_slot_in;
   logic [COUNT_BITS-1:0]     match_cnt_ff, match_cnt_in;
   logic                      free_fnd_ff, free_fnd_in;
   logic [SLOT_W-1:0]         free_slot_ff, free_slot_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   kcst_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic                      load_ok;
   logic                      emit;
   logic                      sel_found;
   logic [SLOT_W-1:0]         sel_slot;
   logic [COUNT_BITS-1:0]     sel_cnt;
   logic [COUNT_BITS-1:0]     cnt_new;
   logic                      key_ok;
   logic                      idx_ok;

   assign load_ok   = !rsp_valid_ff || rsp_ready;
   assign sel_found = match_ff || free_fnd_ff;
   assign sel_slot  = match_ff ? match_slot_ff : free_slot_ff;
   assign sel_cnt   = match_ff ? match_cnt_ff : '0;
   assign cnt_new   = (&sel_cnt) ? sel_cnt : sel_cnt + COUNT_BITS'(1);
   assign key_ok    = 32'(key_ff) < 32'(ITEM_ID_LIMIT);
   assign idx_ok    = 32'(idx_ff) < 32'(SLOTS);

   assign tbl_rd_addr  = issue_ff[SLOT_W-1:0];
   assign tbl_wr_addr  = (state_ff == ST_CLR) ? SLOT_W'(idx_ff) : sel_slot;
   assign tbl_wr_key   = key_ff;
   assign tbl_wr_count = cnt_new;

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      issue_in      = issue_ff;
      match_in      = match_ff;
      match_slot_in = match_slot_ff;
      match_cnt_in  = match_cnt_ff;
      free_fnd_in   = free_fnd_ff;
      free_slot_in  = free_slot_ff;
      rsp_data_in   = rsp_data_ff;
      req_ready     = 1'b0;
      emit          = 1'b0;
      tbl_cmd       = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in      = req_data.item_key;
               idx_in      = req_data.slot_index;
               issue_in    = '0;
               match_in    = 1'b0;
               free_fnd_in = 1'b0;
               state_in    = (req_data.func == kcst_pkg::FUNC_CLEAR) ? ST_CLR : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_ff < (SLOT_W+1)'(SLOTS)) begin
               tbl_cmd.rd_en = 1'b1;
               issue_in      = issue_ff + (SLOT_W+1)'(1);
            end
            if (cmp_vld_ff) begin
               if (tbl_rd_valid && tbl_rd_key == key_ff && !match_ff) begin
                  match_in      = 1'b1;
                  match_slot_in = cmp_addr_ff;
                  match_cnt_in  = tbl_rd_count;
               end
               if (!tbl_rd_valid && !free_fnd_ff) begin
                  free_fnd_in  = 1'b1;
                  free_slot_in = cmp_addr_ff;
               end
               if (cmp_addr_ff == SLOT_W'(SLOTS - 1)) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (load_ok) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               if (!sel_found) begin
                  rsp_data_in.status    = kcst_pkg::STATUS_FULL;
                  rsp_data_in.slot_used = '0;
                  rsp_data_in.new_count = '0;
               end else if (!key_ok) begin
                  rsp_data_in.status    = kcst_pkg::STATUS_RANGE;
                  rsp_data_in.slot_used = '0;
                  rsp_data_in.new_count = '0;
               end else begin
                  tbl_cmd.wr_en         = 1'b1;
                  tbl_cmd.set_vld       = 1'b1;
                  rsp_data_in.status    = kcst_pkg::STATUS_DONE;
                  rsp_data_in.slot_used = 4'(sel_slot);
                  rsp_data_in.new_count = 16'(cnt_new);
               end
               rsp_data_in.free_slots = 5'(tbl_free_next);
            end
         end
         ST_CLR: begin
            if (load_ok) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               if (idx_ok) begin
                  tbl_cmd.clr_vld       = 1'b1;
                  rsp_data_in.status    = kcst_pkg::STATUS_DONE;
                  rsp_data_in.slot_used = idx_ff;
               end else begin
                  rsp_data_in.status    = kcst_pkg::STATUS_RANGE;
                  rsp_data_in.slot_used = '0;
               end
               rsp_data_in.new_count  = '0;
               rsp_data_in.free_slots = 5'(tbl_free_next);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign cmp_vld_in   = tbl_cmd.rd_en;
   assign cmp_addr_in  = tbl_rd_addr;
   assign rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         match_ff     <= 1'b0;
         free_fnd_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         match_ff     <= match_in;
         free_fnd_ff  <= free_fnd_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      issue_ff      <= issue_in;
      cmp_addr_ff   <= cmp_addr_in;
      match_slot_ff <= match_slot_in;
      match_cnt_ff  <= match_cnt_in;
      free_slot_ff  <= free_slot_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/keyed_counting_slot_table.sv =====
// top level of the keyed counting slot table
// depends on kcst_pkg, kcst_req_if, kcst_rsp_if, kcst_table, kcst_ctrl
//
//   channel   dir  modport  payload
//   req_chan  in   sink     func, item_key, slot_index
//   rsp_chan  out  source   status, slot_used, new_count, free_slots
//
// add: the transfer is taken, then the key/count memory is read one slot
//   per cycle through its single read port, then an update step follows
// clear: the transfer is taken, then an update step follows
// reset clears the valid bits and free counter; no clearing pass
// a waiting response stalls only the update step; a new request is taken
//   while the previous response sits in the output register
`default_nettype none

module keyed_counting_slot_table #(
   parameter int SLOTS         = 16,
   parameter int ITEM_ID_LIMIT = 16,
   parameter int COUNT_BITS    = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   kcst_req_if.sink   req_chan,
   kcst_rsp_if.source rsp_chan
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int FREE_W = $clog2(SLOTS + 1);

   kcst_pkg::tbl_cmd_type   tbl_cmd;
   logic [SLOT_W-1:0]       tbl_rd_addr;
   logic [SLOT_W-1:0]       tbl_wr_addr;
   logic [7:0]              tbl_wr_key;
   logic [COUNT_BITS-1:0]   tbl_wr_count;
   logic [7:0]              tbl_rd_key;
   logic [COUNT_BITS-1:0]   tbl_rd_count;
   logic                    tbl_rd_valid;
   logic [FREE_W-1:0]       tbl_free_next;

   kcst_ctrl #(
      .SLOTS         (SLOTS),
      .ITEM_ID_LIMIT (ITEM_ID_LIMIT),
      .COUNT_BITS    (COUNT_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_data      (req_chan.payload),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_data      (rsp_chan.payload),
      .tbl_cmd       (tbl_cmd),
      .tbl_rd_addr   (tbl_rd_addr),
      .tbl_wr_addr   (tbl_wr_addr),
      .tbl_wr_key    (tbl_wr_key),
      .tbl_wr_count  (tbl_wr_count),
      .tbl_rd_key    (tbl_rd_key),
      .tbl_rd_count  (tbl_rd_count),
      .tbl_rd_valid  (tbl_rd_valid),
      .tbl_free_next (tbl_free_next)
   );

   kcst_table #(
      .SLOTS      (SLOTS),
      .COUNT_BITS (COUNT_BITS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .cmd       (tbl_cmd),
      .rd_addr   (tbl_rd_addr),
      .wr_addr   (tbl_wr_addr),
      .wr_key    (tbl_wr_key),
      .wr_count  (tbl_wr_count),
      .rd_key    (tbl_rd_key),
      .rd_count  (tbl_rd_count),
      .rd_valid  (tbl_rd_valid),
      .free_next (tbl_free_next)
   );

endmodule

`default_nettype wire

// ===== rtl/core/kcst_checker.sv =====
// port-level checks of the slot table, bound to the top level
// depends on kcst_pkg and keyed_counting_slot_table_macros.svh
`default_nettype none
`include "keyed_counting_slot_table_macros.svh"

module kcst_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_status,
   input wire logic [3:0] rsp_slot_used,
   input wire logic [15:0] rsp_new_count
);

   logic rsp_stall;
   logic rsp_failed;
   logic rsp_zeroed;
   logic req_xfer;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign rsp_failed = rsp_valid && rsp_status != kcst_pkg::STATUS_DONE;
   assign rsp_zeroed = rsp_slot_used == 4'd0 && rsp_new_count == 16'd0;
   assign req_xfer   = req_valid && req_ready;

   // a response waiting for transfer stays offered
   `KCST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid)

   // failed requests report slot zero and count zero
   `KCST_ASSERT_NOW(a_fail_zero, clock, reset, rsp_failed, rsp_zeroed)

   // one request at a time: the input is closed in the cycle after a request is taken
   `KCST_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_xfer, !req_ready)

   // reset empties the output register
   `KCST_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind keyed_counting_slot_table kcst_checker u_kcst_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_status    (rsp_chan.payload.status),
   .rsp_slot_used (rsp_chan.payload.slot_used),
   .rsp_new_count (rsp_chan.payload.new_count)
);

`default_nettype wire
